>>> sv/cwt_pkg.sv
package cwt_pkg;

    localparam int ID_W = 6;

    typedef enum logic [1:0] {
        OP_TOUCH  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] conn_id;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] expired_id;
        logic            no_expiry;
        logic            last;
    } t_out;

endpackage

>>> sv/connection_timeout_wheel.sv
// Idle-connection timing wheel.
// Input channel (i_in_valid / o_in_stall / i_in_beat) carries commands:
//   touch   records conn_id so it expires WHEEL_SLOTS ticks from now,
//   remove  forgets conn_id, tick expires the current slot.
// Output channel (o_out_valid / i_out_stall / o_out_beat) carries one beat per
// expired connection in ascending id order, or a single no_expiry beat when
// the slot is empty; the final beat of a tick has last set.
// Touch and remove are accepted one per cycle while the block is idle and
// give no beat. A tick holds o_in_stall high while the slot table is swept,
// one entry per cycle through the registered slot memory while the sweep is
// not paused, and until the final beat is loaded into the output register.
// The first expired beat passes the memory read and the hold stage before it
// reaches the output register.
// A stalled output holds its beat; the sweep pauses only when a new match
// finds the hold stage occupied and the output still stalled.
// Reset clears all valid bits, the slot pointer and the output valid flag;
// the slot memory itself is not cleared.
module connection_timeout_wheel #(
    parameter int WHEEL_SLOTS     = 16,
    parameter int MAX_CONNECTIONS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cwt_pkg::t_in   i_in_beat,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cwt_pkg::t_out  o_out_beat
);
    import cwt_pkg::*;

    localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int IDX_W  = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_CONNECTIONS + 1);

    // control and payload registers
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0]   r_rd_slot;
    logic                r_hold_vld, n_hold_vld;
    logic [IDX_W-1:0]    r_hold_idx, n_hold_idx;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic                r_out_vld;
    t_out                r_out, n_out;
    logic                r_valid [MAX_CONNECTIONS];

    // slot memory
    logic [SLOT_W-1:0]   mem_slot [MAX_CONNECTIONS];

    logic                load_out;
    logic                out_free;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [SLOT_W-1:0]   mem_wdata;
    logic                rd_en;
    logic                vset;
    logic                vclr;
    logic [IDX_W-1:0]    vidx;
    logic                in_acc;
    logic                id_ok;
    logic                match;
    logic                blocked;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign id_ok       = ({1'b0, i_in_beat.conn_id} < (ID_W + 1)'(MAX_CONNECTIONS));
    assign match       = r_rd_vld && r_valid[r_rd_idx] && (r_rd_slot == r_cur);
    assign blocked     = match && r_hold_vld && !out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // next state, memory and valid-bit controls
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_hold_vld = r_hold_vld;
        n_hold_idx = r_hold_idx;
        n_cur      = r_cur;
        n_out      = r_out;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = i_in_beat.conn_id[IDX_W-1:0];
        mem_wdata  = (r_cur == '0) ? SLOT_W'(WHEEL_SLOTS - 1) : r_cur - 1'b1;
        rd_en      = 1'b0;
        vset       = 1'b0;
        vclr       = 1'b0;
        vidx       = i_in_beat.conn_id[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_beat.op)
                        OP_TOUCH: begin
                            mem_we = id_ok;
                            vset   = id_ok;
                        end
                        OP_REMOVE: begin
                            vclr = id_ok;
                        end
                        OP_TICK: begin
                            n_state  = ST_SCAN;
                            n_idx    = '0;
                            n_rd_vld = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // take a match into the hold stage, pushing the older one out
                if (match && !blocked) begin
                    if (r_hold_vld) begin
                        load_out         = 1'b1;
                        n_out.expired_id = ID_W'(r_hold_idx);
                        n_out.no_expiry  = 1'b0;
                        n_out.last       = 1'b0;
                    end
                    n_hold_vld = 1'b1;
                    n_hold_idx = r_rd_idx;
                    vclr       = 1'b1;
                    vidx       = r_rd_idx;
                end
                // advance the sweep
                if (!blocked) begin
                    rd_en    = (r_idx < CNT_W'(MAX_CONNECTIONS));
                    n_rd_vld = rd_en;
                    n_rd_idx = r_idx[IDX_W-1:0];
                    if (rd_en) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // emit the final beat and advance the wheel
                if (out_free) begin
                    load_out         = 1'b1;
                    n_out.expired_id = r_hold_vld ? ID_W'(r_hold_idx) : '0;
                    n_out.no_expiry  = !r_hold_vld;
                    n_out.last       = 1'b1;
                    n_hold_vld       = 1'b0;
                    n_cur            = (r_cur == SLOT_W'(WHEEL_SLOTS - 1)) ? '0
                                                                           : r_cur + 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_cur      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rd_vld   <= n_rd_vld;
            r_hold_vld <= n_hold_vld;
            r_cur      <= n_cur;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_hold_idx <= n_hold_idx;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CONNECTIONS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (vset) begin
            r_valid[vidx] <= 1'b1;
        end else if (vclr) begin
            r_valid[vidx] <= 1'b0;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_slot[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_slot <= mem_slot[r_idx[IDX_W-1:0]];
        end
    end

    // checks
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_vld)
        else $error("hold stage occupied outside a tick");

    a_rd_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("read stage active outside the sweep");

    a_cur_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != $past(r_cur)) |-> ($past(r_state) == ST_DONE))
        else $error("slot pointer moved outside tick completion");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur} < (SLOT_W + 1)'(WHEEL_SLOTS)))
        else $error("slot pointer out of range");

    a_none_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.no_expiry) |-> (r_out.last && (r_out.expired_id == '0)))
        else $error("no_expiry beat malformed");

endmodule

>>> test/connection_timeout_wheel_checker.sv
`timescale 1ns / 100ps

// Watches both channels, mirrors the wheel and checks every expiry beat.
module connection_timeout_wheel_checker #(
    parameter int WHEEL_SLOTS     = 16,
    parameter int MAX_CONNECTIONS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  cwt_pkg::t_in  i_in_beat,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  cwt_pkg::t_out i_out_beat,
    input  logic          i_end,
    output int            o_errors,
    output int            o_pending,
    output int            o_beats,
    output int            o_widest
);
    import cwt_pkg::*;

    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int TABLE_DEPTH = 1 << ID_W;

    // Mirror of the connection table and the wheel hand
    logic              conn_live [TABLE_DEPTH];
    logic [SLOT_W-1:0] conn_home [TABLE_DEPTH];
    logic [SLOT_W-1:0] hand;
    t_out              expiry_q[$];
    int                err_cnt;
    int                beat_cnt;
    int                widest_tick;
    bit                end_seen;

    // Expire the slot under the hand in ascending id order, then advance the hand
    function automatic void sweep_hand();
        int hits;
        hits = 0;
        for (int i = 0; i < MAX_CONNECTIONS && i < TABLE_DEPTH; i++) begin
            if (conn_live[i] && conn_home[i] == hand) begin
                conn_live[i] = 1'b0;
                expiry_q.push_back(t_out'{expired_id: i[ID_W-1:0], no_expiry: 1'b0,
                                          last: 1'b0});
                hits++;
            end
        end
        if (hits == 0) begin
            expiry_q.push_back(t_out'{expired_id: '0, no_expiry: 1'b1, last: 1'b1});
        end else begin
            expiry_q[expiry_q.size() - 1].last = 1'b1;
        end
        if (hits > widest_tick) widest_tick = hits;
        hand = SLOT_W'((int'(hand) + 1) % WHEEL_SLOTS);
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                conn_live[i] = 1'b0;
                conn_home[i] = '0;
            end
            hand = '0;
            expiry_q.delete();
            err_cnt = 0;
            beat_cnt = 0;
            widest_tick = 0;
            end_seen = 1'b0;
        end else begin
            // Apply each accepted command beat to the mirror
            if (i_in_valid && !i_in_stall) begin
                case (i_in_beat.op)
                    OP_TOUCH: begin
                        if (int'(i_in_beat.conn_id) < MAX_CONNECTIONS) begin
                            conn_home[i_in_beat.conn_id] =
                                SLOT_W'((int'(hand) + WHEEL_SLOTS - 1) % WHEEL_SLOTS);
                            conn_live[i_in_beat.conn_id] = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (int'(i_in_beat.conn_id) < MAX_CONNECTIONS)
                            conn_live[i_in_beat.conn_id] = 1'b0;
                    end
                    OP_TICK: sweep_hand();
                    default: ;
                endcase
            end

            // Compare each accepted expiry beat with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                beat_cnt++;
                if (expiry_q.size() == 0) begin
                    err_cnt++;
                    $display({"%0t: unexpected beat, expected none, ",
                              "actual id %0d none %0b last %0b"},
                             $time, i_out_beat.expired_id, i_out_beat.no_expiry,
                             i_out_beat.last);
                end else begin
                    want = expiry_q.pop_front();
                    if (i_out_beat.expired_id !== want.expired_id ||
                        i_out_beat.no_expiry !== want.no_expiry ||
                        i_out_beat.last !== want.last) begin
                        err_cnt++;
                        $display({"%0t: mismatch, expected id %0d none %0b last %0b, ",
                                  "actual id %0d none %0b last %0b"},
                                 $time, want.expired_id, want.no_expiry, want.last,
                                 i_out_beat.expired_id, i_out_beat.no_expiry,
                                 i_out_beat.last);
                    end
                end
            end

            // Count predictions still waiting once the run is over
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (expiry_q.size() != 0) begin
                    err_cnt += expiry_q.size();
                    $display({"%0t: %0d expected beats never arrived, ",
                              "first expected id %0d none %0b last %0b"},
                             $time, expiry_q.size(), expiry_q[0].expired_id,
                             expiry_q[0].no_expiry, expiry_q[0].last);
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= expiry_q.size();
        o_beats   <= beat_cnt;
        o_widest  <= widest_tick;
    end

endmodule

>>> test/connection_timeout_wheel_tb.sv
`timescale 1ns / 100ps

module connection_timeout_wheel_tb;

    import cwt_pkg::*;

    localparam int WHEEL_SLOTS     = 16;
    localparam int MAX_CONNECTIONS = 64;
    localparam int ITEMS           = 370;
    localparam int SETTLE_CYCLES   = MAX_CONNECTIONS + 12;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int GAP_MAX         = 5;
    localparam int RECENT_DEPTH    = 16;
    localparam t_op OP_UNUSED      = t_op'(2'd3);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_beat   = '0;
    logic out_stall = 1'b0;
    logic end_check = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_beat;

    int errors, pending, beats, widest;
    int cycles     = 0;
    int gap_max    = GAP_MAX;
    int stall_left = 0;
    bit out_quiet  = 1'b0;
    int n_items    = 0;
    int n_touch    = 0;
    int n_remove   = 0;
    int n_tick     = 0;
    int n_unused   = 0;
    logic [ID_W-1:0] recent[$];

    connection_timeout_wheel #(
        .WHEEL_SLOTS     (WHEEL_SLOTS),
        .MAX_CONNECTIONS (MAX_CONNECTIONS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    connection_timeout_wheel_checker #(
        .WHEEL_SLOTS     (WHEEL_SLOTS),
        .MAX_CONNECTIONS (MAX_CONNECTIONS)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .i_end       (end_check),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_beats     (beats),
        .o_widest    (widest)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall a random number of cycles after each beat, with quiet stretches
    always @(posedge clk) begin
        int wait_cycles;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (out_valid && !out_stall) begin
            if ($urandom_range(0, 29) == 0) out_quiet <= !out_quiet;
            wait_cycles = out_quiet ? 0 : $urandom_range(0, GAP_MAX);
            out_stall   <= (wait_cycles != 0);
            stall_left  <= (wait_cycles != 0) ? wait_cycles - 1 : 0;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Send one command beat after a random gap and hold it until accepted
    task automatic issue(input t_op op, input logic [ID_W-1:0] id);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= t_in'{op: op, conn_id: id};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (op)
            OP_TOUCH: begin
                n_touch++;
                recent.push_back(id);
                if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
            end
            OP_REMOVE: n_remove++;
            OP_TICK:   n_tick++;
            default:   n_unused++;
        endcase
        if (op != OP_UNUSED) n_items++;
    endtask

    // Hold off the sender until every expiry has drained and the sweep is over
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly pick a recently touched id so removes and refreshes hit live entries
    function automatic logic [ID_W-1:0] pick_id();
        if (recent.size() != 0 && $urandom_range(0, 2) != 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    initial begin
        int kind;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, refresh, remove present and absent, unused code, empty tick
        issue(OP_TOUCH, 6'd0);
        issue(OP_TOUCH, 6'd63);
        issue(OP_TOUCH, 6'd42);
        issue(OP_TOUCH, 6'd21);
        issue(OP_TOUCH, 6'd0);
        issue(OP_REMOVE, 6'd42);
        issue(OP_REMOVE, 6'd5);
        issue(OP_UNUSED, 6'd63);
        issue(OP_TICK, 6'd63);
        // Refresh moves 21 one slot later than 0 and 63
        issue(OP_TOUCH, 6'd21);
        repeat (WHEEL_SLOTS - 1) issue(OP_TICK, pick_id());
        drain();

        // Fill the whole table back to back, then sweep until all expire in one tick
        gap_max = 0;
        for (int i = (1 << ID_W) - 1; i >= 0; i--) issue(OP_TOUCH, i[ID_W-1:0]);
        gap_max = GAP_MAX;
        repeat (WHEEL_SLOTS) issue(OP_TICK, pick_id());
        drain();

        // Random mix of fill, sweep, churn and noise segments
        while (n_items < ITEMS) begin
            kind    = $urandom_range(0, 9);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            if (kind <= 3) begin
                n = $urandom_range(1, 10);
                repeat (n) issue(OP_TOUCH, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
            end else if (kind <= 6) begin
                n = $urandom_range(1, 6);
                repeat (n) issue(OP_TICK, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
                if ($urandom_range(0, 7) == 0) drain();
            end else if (kind <= 8) begin
                n = $urandom_range(1, 6);
                repeat (n) issue(($urandom_range(0, 1) == 0) ? OP_REMOVE : OP_TOUCH,
                                 pick_id());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) issue(t_op'($urandom_range(0, 3)), pick_id());
            end
        end

        // Wait for the last expiries, then close the books
        drain();
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sent %0d commands: %0d touches, %0d removes, %0d ticks, plus %0d unused codes.",
                 n_items, n_touch, n_remove, n_tick, n_unused);
        $display("Checked %0d expiry beats; widest tick expired %0d connections.",
                 beats, widest);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/cwt_pkg.sv
sv/connection_timeout_wheel.sv
test/connection_timeout_wheel_checker.sv
test/connection_timeout_wheel_tb.sv
